### hw/rtl/sse_pkg.sv
// Package with shared constants and codes for the Shell sort engine.
`default_nettype none

package sse_pkg;

    localparam int DEFAULT_MAX_ELEMENTS = 1024;
    localparam int DEFAULT_DATA_WIDTH   = 32;

    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 10;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/sse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/shell_sort_engine.sv
// Top level of the Shell sort engine: load, sort sequencer and read-out.
//
// Requests arrive on the s_ channel. A load request (s_mode = 0) writes
// s_value into the store and produces no result. A load with s_last set
// closes the set and starts an in-place Shell sort with halving gaps. The
// first load after a sort starts a new set; loads beyond MAX_ELEMENTS are
// dropped, but their last flag still starts the sort. A read request
// (s_mode = 1) waits in ST_RD_WAIT for a free output register, then raises
// m_valid with the sorted value at s_position and m_valid_res high, or zero
// with m_valid_res low when the position is outside the sorted set. Loads
// are taken every cycle while idle; a read holds off new requests until
// its result is registered. The sort is run by one compare unit and a
// single-read-port RAM: ST_JSTEP reads each element of a gap pass, ST_HOLD
// holds it and reads the one a gap below, ST_CMP compares and writes, and
// each upward move adds ST_PROBE and ST_CMP; each gap starts in ST_GAP.
// s_ready stays low while the sort runs and while a read waits for the
// output register. The output register holds its result until m_ready is
// high; loads are still taken while a result waits.
// Reset clears the count, the sorted flag and the output valid; the
// store itself is not cleared and needs no clearing pass.
`default_nettype none

module shell_sort_engine
    import sse_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS,
    parameter int DATA_WIDTH   = DEFAULT_DATA_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_mode,
    input  wire logic signed [VALUE_W-1:0]    s_value,
    input  wire logic        [POSITION_W-1:0] s_position,
    input  wire logic                         s_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed      [VALUE_W-1:0]    m_sorted_value,
    output logic                              m_valid_res
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_GAP,
        ST_JSTEP,
        ST_HOLD,
        ST_CMP,
        ST_PROBE
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          sorted_reg, sorted_next;
    logic [CW-1:0] gap_reg, gap_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [DATA_WIDTH-1:0] hold_reg, hold_next;
    logic          hit_reg, hit_next;
    logic          m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0] m_data_reg, m_data_next;
    logic          m_res_reg, m_res_next;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic [CW-1:0]        load_base;
    logic                 load_room;
    logic [CW-1:0]        load_count;
    logic signed [63:0]   load_wide;
    logic signed [63:0]   rd_wide;
    logic [CW-1:0]        k_minus_gap;

    sse_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_data_reg;
    assign m_valid_res    = m_res_reg;

    assign load_base   = sorted_reg ? '0 : count_reg;
    assign load_room   = (load_base < CW'(MAX_ELEMENTS));
    assign load_count  = load_room ? load_base + CW'(1) : load_base;
    assign load_wide   = 64'(s_value);
    assign rd_wide     = 64'($signed(rd_data));
    assign k_minus_gap = k_reg - gap_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        sorted_next  = sorted_reg;
        gap_next     = gap_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        hold_next    = hold_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_res_next   = m_res_reg;
        wr_en        = 1'b0;
        wr_addr      = k_reg[AW-1:0];
        wr_data      = hold_reg;
        rd_en        = 1'b0;
        rd_addr      = AW'(s_position);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode == MODE_LOAD) begin
                        sorted_next = 1'b0;
                        count_next  = load_count;
                        if (load_room) begin
                            wr_en   = 1'b1;
                            wr_addr = load_base[AW-1:0];
                            wr_data = load_wide[DATA_WIDTH-1:0];
                        end
                        if (s_last) begin
                            gap_next   = load_count >> 1;
                            state_next = ST_GAP;
                        end
                    end else begin
                        rd_en      = 1'b1;
                        hit_next   = sorted_reg && (32'(s_position) < 32'(count_reg));
                        state_next = ST_RD_WAIT;
                    end
                end
            end
            ST_RD_WAIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = hit_reg ? rd_wide[VALUE_W-1:0] : '0;
                    m_res_next   = hit_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_GAP: begin
                if (gap_reg == '0) begin
                    sorted_next = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    j_next     = gap_reg;
                    state_next = ST_JSTEP;
                end
            end
            ST_JSTEP: begin
                if (j_reg >= count_reg) begin
                    gap_next   = gap_reg >> 1;
                    state_next = ST_GAP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = j_reg[AW-1:0];
                    k_next     = j_reg;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                hold_next  = rd_data;
                rd_en      = 1'b1;
                rd_addr    = k_minus_gap[AW-1:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                wr_en = 1'b1;
                if ($signed(hold_reg) < $signed(rd_data)) begin
                    wr_data    = rd_data;
                    k_next     = k_minus_gap;
                    state_next = ST_PROBE;
                end else begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_JSTEP;
                end
            end
            ST_PROBE: begin
                if (k_reg >= gap_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = k_minus_gap[AW-1:0];
                    state_next = ST_CMP;
                end else begin
                    wr_en      = 1'b1;
                    j_next     = j_reg + CW'(1);
                    state_next = ST_JSTEP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sorted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sorted_reg  <= sorted_next;
            m_valid_reg <= m_valid_next;
        end
        gap_reg    <= gap_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        hold_reg   <= hold_next;
        hit_reg    <= hit_next;
        m_data_reg <= m_data_next;
        m_res_reg  <= m_res_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ELEMENTS))
        else $error("Element count exceeds the store capacity.");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD || state_reg == ST_CMP || state_reg == ST_PROBE)
        |-> (k_reg <= j_reg && j_reg < count_reg))
        else $error("Sort indexes left the loaded range.");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_res_reg) |-> (m_data_reg == '0))
        else $error("A result outside the sorted set carries a nonzero value.");

    a_last_starts_sort: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode == MODE_LOAD && s_last)
        |=> (state_reg == ST_GAP && !sorted_reg))
        else $error("A closing load did not start the sort.");

endmodule

`default_nettype wire

### verif/sorted_read_checker.sv
// Checker that predicts the sort engine's read results and compares them on the m_ channel.
module sorted_read_checker
    import sse_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire logic                         s_mode,
    input  wire logic signed [VALUE_W-1:0]    s_value,
    input  wire logic        [POSITION_W-1:0] s_position,
    input  wire logic                         s_last,
    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire logic signed [VALUE_W-1:0]    m_sorted_value,
    input  wire logic                         m_valid_res,
    output int                                failures,
    output int                                pending
);

    localparam int CAPACITY = DEFAULT_MAX_ELEMENTS;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      in_range;
    } read_result_t;

    logic signed [VALUE_W-1:0] held_values [CAPACITY];
    int unsigned               held_count  = 0;
    bit                        held_sorted = 1'b0;
    read_result_t              expected_reads [$];

    initial begin
        failures = 0;
        pending  = 0;
    end

    function automatic void shell_sort_held(int unsigned n);
        int unsigned               gap;
        int unsigned               j;
        int unsigned               k;
        logic signed [VALUE_W-1:0] hold;
        gap = n / 2;
        while (gap > 0) begin
            for (j = gap; j < n; j++) begin
                hold = held_values[j];
                k = j;
                while (k >= gap && hold < held_values[k - gap]) begin
                    held_values[k] = held_values[k - gap];
                    k -= gap;
                end
                held_values[k] = hold;
            end
            gap = gap / 2;
        end
    endfunction

    function automatic void take_load(logic signed [VALUE_W-1:0] value, logic last);
        if (held_sorted) begin
            held_count  = 0;
            held_sorted = 1'b0;
        end
        if (held_count < CAPACITY) begin
            held_values[held_count] = value;
            held_count++;
        end
        if (last) begin
            shell_sort_held(held_count);
            held_sorted = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        read_result_t want;
        if (!aresetn) begin
            held_count  = 0;
            held_sorted = 1'b0;
            expected_reads.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected read result: expected none, %s",
                             $time, $sformatf("got value %0d valid %0b",
                                              m_sorted_value, m_valid_res));
                    failures++;
                end else begin
                    want = expected_reads.pop_front();
                    if (m_sorted_value !== want.value || m_valid_res !== want.in_range) begin
                        $display("%0t: read result mismatch: expected value %0d valid %0b, %s",
                                 $time, want.value, want.in_range,
                                 $sformatf("got value %0d valid %0b",
                                           m_sorted_value, m_valid_res));
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_mode == MODE_LOAD) begin
                    take_load(s_value, s_last);
                end else begin
                    if (held_sorted && s_position < held_count) begin
                        want.value    = held_values[s_position];
                        want.in_range = 1'b1;
                    end else begin
                        want.value    = '0;
                        want.in_range = 1'b0;
                    end
                    expected_reads.push_back(want);
                end
            end
        end
        pending = expected_reads.size();
    end

endmodule

### verif/shell_sort_engine_test.sv
// Testbench top for the Shell sort engine: request stimulus, idling and the final verdict.
module shell_sort_engine_test;
    import sse_pkg::*;

    localparam int TOTAL_REQUESTS = 1950;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int CAPACITY       = DEFAULT_MAX_ELEMENTS;

    logic                         aclk       = 1'b0;
    logic                         aresetn    = 1'b0;
    logic                         s_valid    = 1'b0;
    logic                         s_ready;
    logic                         s_mode     = MODE_LOAD;
    logic signed [VALUE_W-1:0]    s_value    = '0;
    logic        [POSITION_W-1:0] s_position = '0;
    logic                         s_last     = 1'b0;
    logic                         m_valid;
    logic                         m_ready    = 1'b0;
    logic signed [VALUE_W-1:0]    m_sorted_value;
    logic                         m_valid_res;

    int                        failures;
    int                        pending;
    bit                        steady        = 1'b0;
    int                        stall_left    = 0;
    int                        requests_sent = 0;
    int                        set_length    = 0;
    bit                        set_closed    = 1'b0;
    logic signed [VALUE_W-1:0] recent_value  = '0;
    int                        cycle_count   = 0;

    shell_sort_engine u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_value        (s_value),
        .s_position     (s_position),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_valid_res    (m_valid_res)
    );

    sorted_read_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_value        (s_value),
        .s_position     (s_position),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_valid_res    (m_valid_res),
        .failures       (failures),
        .pending        (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int idle_length();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin
        if (stall_left == 0 && $urandom_range(0, 4) == 0) begin
            stall_left = idle_length();
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return $urandom;
        end
        if (r < 7) begin
            return VALUE_W'($urandom_range(0, 20)) - 10;
        end
        if (r == 7) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFFFFFF;
                1: return 32'sh80000000;
                2: return '0;
                default: return -1;
            endcase
        end
        return recent_value;
    endfunction

    function automatic int pick_position();
        int bound;
        int r;
        bound = (set_length > 0) ? set_length : 1;
        r = $urandom_range(0, 19);
        if (r < 15) begin
            return $urandom_range(0, bound - 1);
        end
        if (r < 19) begin
            return (bound + 3 > CAPACITY - 1) ? CAPACITY - 1 : bound + $urandom_range(0, 3);
        end
        return $urandom_range(0, CAPACITY - 1);
    endfunction

    task automatic send_request(logic mode, logic signed [VALUE_W-1:0] value,
                                logic [POSITION_W-1:0] position, logic last);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_value    <= value;
        s_position <= position;
        s_last     <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        requests_sent++;
    endtask

    task automatic load_value(logic signed [VALUE_W-1:0] value, logic last);
        if (set_closed) begin
            set_length = 0;
            set_closed = 1'b0;
        end
        if (set_length < CAPACITY) begin
            set_length++;
        end
        if (last) begin
            set_closed = 1'b1;
        end
        recent_value = value;
        send_request(MODE_LOAD, value, POSITION_W'($urandom), last);
    endtask

    task automatic read_position(int position);
        send_request(MODE_READ, $urandom, POSITION_W'(position), 1'($urandom));
    endtask

    task automatic run_set(int size, bit closes, int reads);
        for (int i = 0; i < size; i++) begin
            load_value(pick_value(), closes && i == size - 1);
            if ($urandom_range(0, 14) == 0) begin
                read_position(pick_position());
            end
        end
        repeat (reads) read_position(pick_position());
    endtask

    initial begin
        int shape;
        int size;
        bit full_done;
        full_done = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        read_position(0);
        read_position(CAPACITY - 1);
        load_value(5, 1'b1);
        read_position(0);
        read_position(1);
        load_value(32'sh7FFFFFFF, 1'b0);
        load_value(32'sh80000000, 1'b0);
        read_position(0);
        load_value(0, 1'b0);
        load_value(-1, 1'b0);
        load_value(1, 1'b0);
        load_value(32'sh80000000, 1'b1);
        for (int p = 0; p < 7; p++) begin
            read_position(p);
        end
        read_position(CAPACITY - 1);

        while (requests_sent < TOTAL_REQUESTS) begin
            steady = ($urandom_range(0, 7) == 0);
            shape  = $urandom_range(0, 9);
            if (!full_done && requests_sent >= 400) begin
                // At least two loads past capacity; the dropped final one still closes the set.
                run_set(CAPACITY + 2, 1'b1, 40);
                full_done = 1'b1;
            end else begin
                size = (shape == 0) ? $urandom_range(33, 100) : $urandom_range(1, 24);
                run_set(size, shape != 1, (shape == 2) ? 0 : $urandom_range(1, size + 4));
            end
        end
        s_valid <= 1'b0;
        steady = 1'b1;

        do @(negedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
